>>> sv/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants of the cache miss counter
// Address split, tag store row layout and the record that carries the
// lookup decision and the tag store write port.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int unsigned ADDR_BITS  = 32;
  localparam int unsigned LINE_SIZE  = 32;
  localparam int unsigned SETS       = 64;
  localparam int unsigned WAYS       = 2;
  localparam int unsigned MISS_BITS  = 40;

  localparam int unsigned LINE_BITS = $clog2(LINE_SIZE);
  localparam int unsigned SET_BITS  = $clog2(SETS);
  localparam int unsigned TAG_BITS  = ADDR_BITS - LINE_BITS - SET_BITS;

  typedef logic [ADDR_BITS-1:0]     addr_t;
  typedef logic [SET_BITS-1:0]      set_t;
  typedef logic [TAG_BITS-1:0]      tag_t;
  typedef tag_t [WAYS-1:0]          row_t;
  typedef logic [WAYS-1:0]          valid_row_t;
  typedef logic                     way_t;
  typedef logic [MISS_BITS-1:0]     miss_t;

  localparam miss_t MISS_MAX = '1;

  typedef struct packed {
    logic hit;
    way_t way;
  } lookup_t;

  // One row of the tag store: least recent way, valid bits and tags of a set.
  typedef struct packed {
    way_t       lru;
    valid_row_t valid;
    row_t       tags;
  } entry_t;

  typedef struct packed {
    logic   en;
    set_t   set;
    entry_t row;
  } ram_wr_t;

endpackage

>>> sv/salc_addr_if.sv
// ----------------------------------------------------------------------------
// salc_addr_if: access request channel
// Carries one byte address per transaction with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface salc_addr_if;
  logic        valid;
  logic        ready;
  logic [31:0] byte_address;

  modport source (output valid, output byte_address, input ready);
  modport sink   (input valid, input byte_address, output ready);
endinterface

>>> sv/salc_result_if.sv
// ----------------------------------------------------------------------------
// salc_result_if: lookup result channel
// Carries hit flag, way used and running miss total per transaction.
// ----------------------------------------------------------------------------
interface salc_result_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        way_used;
  logic [39:0] miss_total;

  modport source (output valid, output hit, output way_used, output miss_total, input ready);
  modport sink   (input valid, input hit, input way_used, input miss_total, output ready);
endinterface

>>> sv/salc_tag_ram.sv
// ----------------------------------------------------------------------------
// salc_tag_ram: tag store
// One row per set holding the tags, valid bits and recency bit of all ways.
// One read and one write port, read data registered.
// ----------------------------------------------------------------------------
module salc_tag_ram
  import salc_pkg::*;
(
  input  logic    clk,
  input  logic    rd_en,
  input  set_t    rd_set,
  output entry_t  rd_row,
  input  ram_wr_t wr
);

  entry_t mem [SETS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.set] <= wr.row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_set];
    end
  end

endmodule

>>> sv/salc_lookup.sv
// ----------------------------------------------------------------------------
// salc_lookup: tag compare and victim choice
// Compares the tag against both ways of a set, picks the hit way or the
// least recent way, and forms the row to write back on a miss.
// ----------------------------------------------------------------------------
module salc_lookup
  import salc_pkg::*;
(
  input  tag_t       tag,
  input  row_t       row,
  input  valid_row_t valid_row,
  input  way_t       lru_way,
  output lookup_t    result,
  output row_t       row_next
);

  logic hit0;
  logic hit1;

  always_comb begin
    hit0 = valid_row[0] && (row[0] == tag);
    hit1 = valid_row[1] && (row[1] == tag);
    result.hit = hit0 || hit1;
    if (hit0) begin
      result.way = 1'b0;
    end else if (hit1) begin
      result.way = 1'b1;
    end else begin
      result.way = lru_way;
    end
    row_next = row;
    row_next[result.way] = tag;
  end

endmodule

>>> sv/set_assoc_lru_cache_miss_counter.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_miss_counter: two-way LRU tag directory with miss count
// Each request transaction carries one byte address. The block splits it into
// set index and tag, looks the tag up in both ways of the set, and returns one
// result transaction: hit flag, the way that hit or was filled, and the
// saturating number of misses since reset including this access.
// Tags, valid bits and the recency bit of a set share one row of a synchronous
// memory that is read in the cycle a request is accepted; compare, replacement
// and write-back of the row happen as the request leaves stage s1, loading the
// output register. A request passes the s1 registers and the output register
// before its result can be taken; one request is taken every cycle unless a
// result is held back. A write to a set followed at once by a read of that set
// is covered by forwarding the last written row. Reset clears the miss count
// and starts a clearing pass that zeroes all 64 rows, leaving all ways invalid
// and way 0 least recent; request ready stays low until the pass ends. While
// the receiver holds ready low with a result waiting, the pipeline holds and
// request ready is low; a result register being emptied lets a new request in.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_miss_counter
  import salc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  salc_addr_if.sink     req,
  salc_result_if.source rsp
);

  logic       advance;
  logic       accept;
  logic       fire;

  logic       clearing;
  set_t       clear_set;

  logic       s1_valid;
  set_t       s1_set;
  tag_t       s1_tag;

  entry_t     ram_row;
  entry_t     row_cur;
  entry_t     entry_next;
  row_t       row_next;
  ram_wr_t    ram_wr;

  logic       last_valid;
  set_t       last_set;
  entry_t     last_row;

  miss_t      miss_count;
  miss_t      miss_count_next;
  lookup_t    look;

  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = advance && !clearing;
  assign accept    = req.valid && advance && !clearing;
  assign fire      = s1_valid && advance;

  salc_tag_ram u_tag_ram (
    .clk    (clk),
    .rd_en  (accept),
    .rd_set (req.byte_address[LINE_BITS +: SET_BITS]),
    .rd_row (ram_row),
    .wr     (ram_wr)
  );

  assign row_cur = (last_valid && (last_set == s1_set)) ? last_row : ram_row;

  salc_lookup u_lookup (
    .tag       (s1_tag),
    .row       (row_cur.tags),
    .valid_row (row_cur.valid),
    .lru_way   (row_cur.lru),
    .result    (look),
    .row_next  (row_next)
  );

  always_comb begin
    entry_next.lru             = ~look.way;
    entry_next.valid           = row_cur.valid;
    entry_next.valid[look.way] = 1'b1;
    entry_next.tags            = row_next;
    ram_wr.en  = clearing || fire;
    if (clearing) begin
      ram_wr.set = clear_set;
      ram_wr.row = entry_t'('0);
    end else begin
      ram_wr.set = s1_set;
      ram_wr.row = entry_next;
    end
    miss_count_next = miss_count;
    if (!look.hit && (miss_count != MISS_MAX)) begin
      miss_count_next = miss_count + miss_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_set <= req.byte_address[LINE_BITS +: SET_BITS];
      s1_tag <= req.byte_address[LINE_BITS + SET_BITS +: TAG_BITS];
    end
    if (ram_wr.en) begin
      last_set <= ram_wr.set;
      last_row <= ram_wr.row;
    end
    if (fire) begin
      rsp.hit        <= look.hit;
      rsp.way_used   <= look.way;
      rsp.miss_total <= miss_count_next;
    end
    if (rst) begin
      clearing   <= 1'b1;
      clear_set  <= '0;
      s1_valid   <= 1'b0;
      last_valid <= 1'b0;
      rsp.valid  <= 1'b0;
      miss_count <= '0;
    end else begin
      if (clearing) begin
        clear_set <= clear_set + set_t'(1);
        if (clear_set == set_t'(SETS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (advance) begin
        s1_valid <= accept;
      end
      if (ram_wr.en) begin
        last_valid <= 1'b1;
      end
      if (fire) begin
        rsp.valid  <= 1'b1;
        miss_count <= miss_count_next;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

>>> test/salc_lookup_checker.sv
// ----------------------------------------------------------------------------
// salc_lookup_checker: result checker of the cache miss counter
// Watches both channels. Every accepted request transaction is run through a
// local two-way LRU directory and the expected hit, way and miss total are
// queued. Every accepted result transaction is compared with the oldest one.
// ----------------------------------------------------------------------------
module salc_lookup_checker
  import salc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  salc_addr_if   req,
  salc_result_if rsp,
  output int     errors,
  output int     pending,
  output int     hits,
  output int     misses
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic  hit;
    way_t  way;
    miss_t total;
  } lookup_result_t;

  tag_t           line_tag   [SETS][WAYS];
  logic           line_valid [SETS][WAYS];
  int unsigned    way_age    [SETS][WAYS];
  miss_t          miss_count;
  lookup_result_t pending_lookups [$];

  assign pending = pending_lookups.size();

  function automatic lookup_result_t predict_lookup(input addr_t addr);
    set_t           s;
    tag_t           t;
    int unsigned    w_sel;
    int unsigned    old_age;
    lookup_result_t r;
    s = addr[LINE_BITS +: SET_BITS];
    t = addr[LINE_BITS+SET_BITS +: TAG_BITS];
    r.hit = 1'b0;
    w_sel = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (!r.hit && line_valid[s][w] && line_tag[s][w] == t) begin
        r.hit = 1'b1;
        w_sel = w;
      end
    end
    if (!r.hit) begin
      for (int w = 1; w < WAYS; w++) begin
        if (way_age[s][w] > way_age[s][w_sel]) w_sel = w;
      end
      line_tag[s][w_sel] = t;
      line_valid[s][w_sel] = 1'b1;
      if (miss_count != MISS_MAX) miss_count++;
    end
    old_age = way_age[s][w_sel];
    for (int w = 0; w < WAYS; w++) begin
      if (way_age[s][w] < old_age) way_age[s][w]++;
    end
    way_age[s][w_sel] = 0;
    r.way = way_t'(w_sel);
    r.total = miss_count;
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          line_valid[s][w] = 1'b0;
          line_tag[s][w] = '0;
          way_age[s][w] = WAYS - 1 - w;
        end
      end
      miss_count = '0;
      pending_lookups.delete();
      errors = 0;
      hits = 0;
      misses = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_lookups.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result transaction with nothing expected: hit=%0b way=%0d misses=%0d",
                     $time, rsp.hit, rsp.way_used, rsp.miss_total);
        end else begin
          want = pending_lookups.pop_front();
          if (want.hit) hits++;
          else misses++;
          if (rsp.hit !== want.hit || rsp.way_used !== want.way ||
              rsp.miss_total !== want.total) begin
            errors++;
            if (errors <= 10)
              $display("%0t: lookup mismatch: expected hit=%0b way=%0d misses=%0d, got hit=%0b way=%0d misses=%0d",
                       $time, want.hit, want.way, want.total,
                       rsp.hit, rsp.way_used, rsp.miss_total);
          end
        end
      end
      if (req.valid && req.ready) pending_lookups.push_back(predict_lookup(req.byte_address));
    end
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the two-way LRU cache miss counter
// Drives directed LRU and eviction cases, then random accesses that mostly
// revisit a few tags in a few sets, with random idling on both channels, one
// long result stall and one mid-run drain. The checker grades every result.
// ----------------------------------------------------------------------------
module tb_top
  import salc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 1650;
  localparam int QUIET_ITEMS  = 300;
  localparam int LONG_HOLD    = 64;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   quiet = 1'b0;
  bit   want_long_hold = 1'b0;
  int   errors;
  int   pending;
  int   hits;
  int   misses;
  int   cycles = 0;

  addr_t       recent [8];
  int unsigned recent_wr = 0;

  salc_addr_if   req_if ();
  salc_result_if rsp_if ();

  set_assoc_lru_cache_miss_counter dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  salc_lookup_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .errors  (errors),
    .pending (pending),
    .hits    (hits),
    .misses  (misses)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic addr_t mk_addr(input tag_t t, input set_t s,
                                    input logic [LINE_BITS-1:0] o);
    return {t, s, o};
  endfunction

  task automatic send_addr(input addr_t a);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.byte_address <= a;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    recent[recent_wr] = a;
    recent_wr = (recent_wr + 1) % 8;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (want_long_hold && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (quiet) begin
        rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 4);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    tag_t                 hot_tag [3];
    addr_t                a;
    set_t                 s;
    tag_t                 t;
    logic [LINE_BITS-1:0] o;
    int                   pick;
    req_if.valid = 1'b0;
    req_if.byte_address = '0;
    foreach (recent[i]) recent[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill, hit, and evict in set 0; fill set 63 from the top of the address space.
    send_addr(32'h0000_0000);
    send_addr(32'hFFFF_FFFF);
    send_addr(mk_addr(tag_t'(0), set_t'(0), 5'd31));
    send_addr(mk_addr(tag_t'(1), set_t'(0), 5'd0));
    send_addr(mk_addr(tag_t'(0), set_t'(0), 5'd5));
    send_addr(mk_addr(tag_t'(2), set_t'(0), 5'd0));
    send_addr(mk_addr(tag_t'(1), set_t'(0), 5'd0));
    send_addr(mk_addr(tag_t'(2), set_t'(0), 5'd7));
    send_addr(mk_addr(tag_t'(1), set_t'(0), 5'd0));
    send_addr(mk_addr('1, set_t'(63), 5'd0));
    send_addr(mk_addr(tag_t'(21'h15_5555), set_t'(63), 5'd16));
    send_addr(mk_addr(tag_t'(0), set_t'(63), 5'd0));
    send_addr(mk_addr('1, set_t'(63), 5'd3));
    send_addr(32'hAAAA_AAAA);
    send_addr(32'h5555_5555);
    send_addr(32'hAAAA_AAAA);
    send_addr(mk_addr('1, set_t'(0), 5'd0));
    // Back-to-back accesses to one set exercise write forwarding.
    send_addr(mk_addr(tag_t'(3), set_t'(5), 5'd0));
    send_addr(mk_addr(tag_t'(3), set_t'(5), 5'd1));
    send_addr(mk_addr(tag_t'(4), set_t'(5), 5'd0));
    send_addr(mk_addr(tag_t'(3), set_t'(5), 5'd0));
    send_addr(mk_addr(tag_t'(4), set_t'(5), 5'd2));
    send_addr(mk_addr(tag_t'(5), set_t'(5), 5'd0));
    send_addr(mk_addr(tag_t'(3), set_t'(5), 5'd0));
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 200 == 0) foreach (hot_tag[i]) hot_tag[i] = tag_t'($urandom);
      if (n == 400) want_long_hold = 1'b1;
      if (n == 800) wait_drained();
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      o = LINE_BITS'($urandom_range(0, LINE_SIZE - 1));
      if (pick < 60) begin
        s = (pick < 45) ? set_t'($urandom_range(0, 7)) : set_t'($urandom_range(0, SETS - 1));
        t = hot_tag[$urandom_range(0, 2)];
        a = {t, s, o};
      end else if (pick < 80) begin
        a = recent[$urandom_range(0, 7)];
        a[LINE_BITS-1:0] = o;
      end else begin
        a = $urandom;
      end
      send_addr(a);
    end

    wait_drained();
    $display("Covered %0d lookups (%0d hits, %0d misses): directed LRU and eviction cases,",
             hits + misses, hits, misses);
    $display("random accesses with idling, a long result stall and a mid-run drain.");
    if (errors == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
